### hw/rtl/ftfd_pkg.sv
package ftfd_pkg;

  localparam int unsigned PosW      = 5;
  localparam int unsigned NumChan   = 6;
  localparam int unsigned WordW     = 32;
  localparam int unsigned ChanIdxW  = 3;

  localparam logic [PosW-1:0] PosHunt      = 5'd0;
  localparam logic [PosW-1:0] PosCountHi   = 5'd3;
  localparam logic [PosW-1:0] PosCountLo   = 5'd4;
  localparam logic [PosW-1:0] PosDataFirst = 5'd5;
  localparam logic [PosW-1:0] PosDataLast  = 5'd28;
  localparam logic [PosW-1:0] PosCheck     = 5'd29;
  localparam logic [PosW-1:0] PosLast      = 5'd30;

  localparam logic [7:0] HeaderReset = 8'd170;
  localparam logic [7:0] TailReset   = 8'd10;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusBadTail  = 2'd1,
    StatusBadCheck = 2'd2
  } status_e;

  typedef enum logic {
    CfgHeader = 1'b0,
    CfgTail   = 1'b1
  } cfg_idx_e;

endpackage

### hw/rtl/force_torque_frame_deframer.sv
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------------------
// cfg       | cfg_we_i                   | cfg_idx_i, cfg_data_i
// in        | in_valid_i / in_ready_o    | rx_byte_i
// out       | out_valid_o / out_ready_i  | frame_status_o, frame_count_o, 6 x 32b
//
// one byte accepted per cycle when ready; frame state registers update on the accepting edge
// a result appears in the cycle after the tail byte (frame position 30) is accepted
// the result register holds until taken; bytes keep flowing, only the next tail byte
// stalls while a result still waits
// rst_ni clears frame state and restores the header and tail values; data words are not reset
module force_torque_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  frame_status_o,
  output logic [15:0] frame_count_o,
  output logic [31:0] force_x_o,
  output logic [31:0] force_y_o,
  output logic [31:0] force_z_o,
  output logic [31:0] torque_x_o,
  output logic [31:0] torque_y_o,
  output logic [31:0] torque_z_o
);

  logic [7:0] header_q, tail_q;
  logic [ftfd_pkg::PosW-1:0] pos_q, pos_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  check_q;
  logic [15:0] count_q;
  logic [ftfd_pkg::WordW-1:0] words_q [ftfd_pkg::NumChan];

  logic        out_valid_q, out_valid_d;
  ftfd_pkg::status_e status_q, status_d;
  logic [15:0] res_count_q;
  logic [ftfd_pkg::WordW-1:0] res_words_q [ftfd_pkg::NumChan];

  logic in_fire, hunting, at_last, in_data;
  logic [ftfd_pkg::PosW-1:0] data_off;
  logic [ftfd_pkg::ChanIdxW-1:0] chan_idx;
  logic [1:0] lane;

  assign hunting = (pos_q == ftfd_pkg::PosHunt) || (pos_q > ftfd_pkg::PosLast);
  assign at_last = (pos_q == ftfd_pkg::PosLast);
  assign in_data = (pos_q >= ftfd_pkg::PosDataFirst) && (pos_q <= ftfd_pkg::PosDataLast);
  assign in_ready_o = !(at_last && out_valid_q && !out_ready_i);
  assign in_fire = in_valid_i && in_ready_o;

  assign data_off = pos_q - ftfd_pkg::PosDataFirst;
  assign chan_idx = data_off[ftfd_pkg::ChanIdxW+1:2];
  assign lane     = data_off[1:0];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= ftfd_pkg::HeaderReset;
      tail_q   <= ftfd_pkg::TailReset;
    end else if (cfg_we_i) begin
      case (ftfd_pkg::cfg_idx_e'(cfg_idx_i))
        ftfd_pkg::CfgHeader: header_q <= cfg_data_i;
        ftfd_pkg::CfgTail:   tail_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame position and checksum
  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (in_fire) begin
      if (hunting) begin
        sum_d = 8'd0;
        pos_d = (rx_byte_i == header_q) ? 5'd1 : ftfd_pkg::PosHunt;
      end else if (at_last) begin
        sum_d = 8'd0;
        pos_d = ftfd_pkg::PosHunt;
      end else begin
        if (in_data) begin
          sum_d = sum_q + rx_byte_i;
        end
        pos_d = pos_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= ftfd_pkg::PosHunt;
      sum_q   <= 8'd0;
      check_q <= 8'd0;
      count_q <= 16'd0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      if (in_fire && pos_q == ftfd_pkg::PosCheck) begin
        check_q <= rx_byte_i;
      end
      if (in_fire && pos_q == ftfd_pkg::PosCountHi) begin
        count_q[15:8] <= rx_byte_i;
      end
      if (in_fire && pos_q == ftfd_pkg::PosCountLo) begin
        count_q[7:0] <= rx_byte_i;
      end
    end
  end

  // little-endian word assembly
  always_ff @(posedge clk_i) begin
    if (in_fire && in_data) begin
      words_q[chan_idx][lane*8 +: 8] <= rx_byte_i;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && at_last) begin
      out_valid_d = 1'b1;
    end
    if (rx_byte_i != tail_q) begin
      status_d = ftfd_pkg::StatusBadTail;
    end else if (check_q != sum_q) begin
      status_d = ftfd_pkg::StatusBadCheck;
    end else begin
      status_d = ftfd_pkg::StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && at_last) begin
      status_q    <= status_d;
      res_count_q <= count_q;
      res_words_q <= words_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_status_o = status_q;
  assign frame_count_o  = res_count_q;
  assign force_x_o      = res_words_q[0];
  assign force_y_o      = res_words_q[1];
  assign force_z_o      = res_words_q[2];
  assign torque_x_o     = res_words_q[3];
  assign torque_y_o     = res_words_q[4];
  assign torque_z_o     = res_words_q[5];

`ifndef SYNTH
  a_tail_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && at_last) |=> out_valid_q)
    else $error("tail byte accepted without a result");

  a_stall_only_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_q && at_last))
    else $error("input stalled without a waiting result");

  a_header_starts_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && hunting && rx_byte_i == header_q) |=> (pos_q == 5'd1))
    else $error("header byte did not start a frame");
`endif

endmodule

### tb/tb_force_torque_frame_deframer.sv
module tb_force_torque_frame_deframer;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseBytes = 420;
  localparam int unsigned NumRows    = 8;

  typedef struct packed {
    ftfd_pkg::status_e   status;
    logic [15:0]         count;
    logic [5:0][31:0]    words;
  } ft_frame_t;

  typedef struct packed {
    logic [1:0]        lead;
    logic [15:0]       count;
    logic [7:0]        fill;
    logic              tail_ok;
    logic              sum_ok;
    logic              typed;
    ftfd_pkg::status_e status;
  } frame_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [7:0]  cfg_data_i = 8'h00;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  frame_status_o;
  logic [15:0] frame_count_o;
  logic [31:0] force_x_o;
  logic [31:0] force_y_o;
  logic [31:0] force_z_o;
  logic [31:0] torque_x_o;
  logic [31:0] torque_y_o;
  logic [31:0] torque_z_o;

  force_torque_frame_deframer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_status_o (frame_status_o),
    .frame_count_o  (frame_count_o),
    .force_x_o      (force_x_o),
    .force_y_o      (force_y_o),
    .force_z_o      (force_z_o),
    .torque_x_o     (torque_x_o),
    .torque_y_o     (torque_y_o),
    .torque_z_o     (torque_z_o)
  );

  // deframer mirror
  logic [7:0]       hdr_val = ftfd_pkg::HeaderReset;
  logic [7:0]       tail_val = ftfd_pkg::TailReset;
  logic [ftfd_pkg::PosW-1:0] hunt_pos = ftfd_pkg::PosHunt;
  logic [7:0]       sum_acc = 8'h00;
  logic [7:0]       check_byte = 8'h00;
  logic [15:0]      count_acc = 16'h0000;
  logic [5:0][31:0] chan_word = '0;

  ft_frame_t   frames_due[$];
  ft_frame_t   typed_frame;
  bit          typed_row = 1'b0;
  bit          calm = 1'b0;
  logic [7:0]  frame_data [24];
  int unsigned bytes_sent = 0;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 35);
  end

  task automatic deframe_byte(input logic [7:0] b, output bit got, output ft_frame_t res);
    int unsigned off;
    got = 1'b0;
    res = '0;
    if (hunt_pos == ftfd_pkg::PosHunt || hunt_pos > ftfd_pkg::PosLast) begin
      hunt_pos = ftfd_pkg::PosHunt;
      sum_acc = 8'h00;
      if (b == hdr_val) begin
        hunt_pos = 5'd1;
      end
    end else if (hunt_pos == ftfd_pkg::PosLast) begin
      if (b != tail_val) begin
        res.status = ftfd_pkg::StatusBadTail;
      end else if (check_byte != sum_acc) begin
        res.status = ftfd_pkg::StatusBadCheck;
      end else begin
        res.status = ftfd_pkg::StatusOk;
      end
      res.count = count_acc;
      res.words = chan_word;
      got = 1'b1;
      hunt_pos = ftfd_pkg::PosHunt;
      sum_acc = 8'h00;
    end else begin
      if (hunt_pos == ftfd_pkg::PosCountHi) begin
        count_acc[15:8] = b;
      end else if (hunt_pos == ftfd_pkg::PosCountLo) begin
        count_acc[7:0] = b;
      end else if (hunt_pos >= ftfd_pkg::PosDataFirst && hunt_pos <= ftfd_pkg::PosDataLast) begin
        off = 32'(hunt_pos - ftfd_pkg::PosDataFirst);
        chan_word[off / 4][(off % 4) * 8 +: 8] = b;
        sum_acc = sum_acc + b;
      end else if (hunt_pos == ftfd_pkg::PosCheck) begin
        check_byte = b;
      end
      hunt_pos = hunt_pos + 1'b1;
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    bit        got;
    bit        taken;
    ft_frame_t res;
    while (!calm && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    taken = 1'b0;
    // ready is stable from the falling edge to the next rising edge
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end
    bytes_sent++;
    deframe_byte(b, got, res);
    if (got) begin
      if (typed_row) begin
        res = typed_frame;
      end
      frames_due.push_back(res);
    end
  endtask

  task automatic send_frame(input logic [15:0] cnt, input bit tail_ok, input bit sum_ok);
    logic [7:0] s;
    s = 8'h00;
    push_byte(hdr_val);
    push_byte(8'($urandom_range(255)));
    push_byte(8'($urandom_range(255)));
    push_byte(cnt[15:8]);
    push_byte(cnt[7:0]);
    for (int i = 0; i < 24; i++) begin
      s = s + frame_data[i];
      push_byte(frame_data[i]);
    end
    push_byte(sum_ok ? s : s ^ 8'($urandom_range(255, 1)));
    push_byte(tail_ok ? tail_val : tail_val ^ 8'($urandom_range(255, 1)));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input ftfd_pkg::cfg_idx_e idx, input logic [7:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == ftfd_pkg::CfgHeader) begin
      hdr_val = value;
    end else begin
      tail_val = value;
    end
  endtask

  always @(posedge clk_i) begin
    ft_frame_t got_frame;
    ft_frame_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_frame.status = ftfd_pkg::status_e'(frame_status_o);
      got_frame.count = frame_count_o;
      got_frame.words = {torque_z_o, torque_y_o, torque_x_o, force_z_o, force_y_o, force_x_o};
      if (frames_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("unexpected frame: status %0d count %h", frame_status_o, frame_count_o);
        end
      end else begin
        want = frames_due.pop_front();
        if (got_frame.status !== want.status || got_frame.count !== want.count ||
            got_frame.words !== want.words) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("frame mismatch: status %0d/%0d count %h/%h", want.status,
                     got_frame.status, want.count, got_frame.count);
            $display("  words expected %h", want.words);
            $display("  words actual   %h", got_frame.words);
          end
        end
      end
    end
  end

  initial begin
    frame_row_t  plan [NumRows];
    int unsigned target;
    int unsigned pick;
    logic [7:0]  noise;
    plan[0] = '{2'd0, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b1, ftfd_pkg::StatusOk};
    plan[1] = '{2'd3, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1, ftfd_pkg::StatusOk};
    plan[2] = '{2'd0, 16'h1234, 8'h5A, 1'b0, 1'b1, 1'b1, ftfd_pkg::StatusBadTail};
    plan[3] = '{2'd1, 16'h8001, 8'hA5, 1'b1, 1'b0, 1'b1, ftfd_pkg::StatusBadCheck};
    plan[4] = '{2'd0, 16'h00FF, 8'h3C, 1'b0, 1'b0, 1'b1, ftfd_pkg::StatusBadTail};
    // header value inside the data bytes
    plan[5] = '{2'd2, 16'hFF00, 8'hAA, 1'b1, 1'b1, 1'b1, ftfd_pkg::StatusOk};
    plan[6] = '{2'd1, 16'h7E81, 8'h00, 1'b1, 1'b1, 1'b0, ftfd_pkg::StatusOk};
    plan[7] = '{2'd0, 16'h0F0F, 8'h00, 1'b0, 1'b0, 1'b0, ftfd_pkg::StatusOk};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      for (int k = 0; k < plan[r].lead; k++) begin
        do noise = 8'($urandom_range(255)); while (noise == hdr_val);
        push_byte(noise);
      end
      for (int i = 0; i < 24; i++) begin
        frame_data[i] = plan[r].typed ? plan[r].fill : 8'($urandom_range(255));
      end
      typed_row = plan[r].typed;
      typed_frame.status = plan[r].status;
      typed_frame.count = plan[r].count;
      typed_frame.words = {24{plan[r].fill}};
      send_frame(plan[r].count, plan[r].tail_ok, plan[r].sum_ok);
      typed_row = 1'b0;
    end

    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin
          write_reg(ftfd_pkg::CfgHeader, ftfd_pkg::HeaderReset);
          write_reg(ftfd_pkg::CfgTail, ftfd_pkg::TailReset);
        end
        1: begin
          write_reg(ftfd_pkg::CfgHeader, 8'h00);
          write_reg(ftfd_pkg::CfgTail, 8'hFF);
        end
        2: begin
          write_reg(ftfd_pkg::CfgHeader, 8'hFF);
          write_reg(ftfd_pkg::CfgTail, 8'h00);
        end
        default: begin
          write_reg(ftfd_pkg::CfgHeader, 8'($urandom_range(255)));
          write_reg(ftfd_pkg::CfgTail, 8'($urandom_range(255)));
        end
      endcase
      cfg_we_i <= 1'b0;
      calm = (phase == 1);
      target = bytes_sent + PhaseBytes;
      while (bytes_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          repeat ($urandom_range(2)) push_byte(8'($urandom_range(255)));
          for (int i = 0; i < 24; i++) begin
            frame_data[i] = 8'($urandom_range(255));
          end
          send_frame(16'($urandom_range(65535)), $urandom_range(99) < 85,
                     $urandom_range(99) < 85);
        end else if (pick < 87) begin
          // cut-off frame
          push_byte(hdr_val);
          repeat ($urandom_range(29, 1)) push_byte(8'($urandom_range(255)));
        end else begin
          repeat ($urandom_range(5, 1)) push_byte(8'($urandom_range(255)));
        end
      end
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
